[rtl/core/wss_pkg.sv]
package wss_pkg;

	localparam int FRAC_BITS_DEF     = 16;
	localparam int K_OFF_DEF         = 32768;
	localparam int OMEGA_AIR_MIN_DEF = 65536;
	localparam int TAU_MAX_DEF       = 65536;

	// round(2^32 / (2*pi)), applied with a floor shift by 32.
	localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;

	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ENABLE,
		REG_YAW_SCALE,
		REG_EPS_ABS,
		REG_K_REL,
		REG_ETA_ON,
		REG_K_DOM,
		REG_K_P,
		REG_K_D
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] speed_left;
		logic signed [31:0] speed_right;
		logic signed [31:0] yaw_rate;
		logic signed [31:0] effort_this;
		logic signed [31:0] effort_other;
		logic signed [31:0] speed_ground;
		logic signed [31:0] speed_air;
		logic signed [31:0] accel_ground;
		logic signed [31:0] accel_air;
	} wss_in_t;

	typedef struct packed {
		logic        [30:0] yaw_error;
		logic               decorrelated;
		logic               slip_candidate;
		logic               recontact;
		logic signed [31:0] sync_torque;
		logic               torque_clamped;
	} wss_out_t;

	typedef struct packed {
		logic               enable;
		logic        [30:0] yaw_scale;
		logic        [30:0] eps_abs;
		logic        [30:0] k_rel;
		logic signed [31:0] eta_on;
		logic        [30:0] k_dom;
		logic signed [31:0] k_p;
		logic signed [31:0] k_d;
	} wss_cfg_t;

	// First stage: differences and operand conditioning shared by both paths.
	typedef struct packed {
		logic signed [32:0] d_speed;
		logic signed [31:0] yaw;
		logic        [31:0] abs_yaw;
		logic signed [31:0] eth;
		logic        [30:0] oth;
		logic signed [32:0] e;
		logic signed [32:0] d_acc;
	} wss_s1_t;

	typedef struct packed {
		logic [30:0] yaw_error;
		logic        decorrelated;
		logic        slip_candidate;
		logic        recontact;
	} wss_yaw_res_t;

endpackage

[rtl/core/wss_yaw_path.sv]
module wss_yaw_path #(
	parameter int FRAC_BITS     = wss_pkg::FRAC_BITS_DEF,
	parameter int K_OFF         = wss_pkg::K_OFF_DEF,
	parameter int OMEGA_AIR_MIN = wss_pkg::OMEGA_AIR_MIN_DEF
) (
	input  logic                  clk,
	input  wss_pkg::wss_s1_t      s1,
	input  wss_pkg::wss_cfg_t     cfg,
	output wss_pkg::wss_yaw_res_t res_s5
);
	import wss_pkg::*;

	localparam int PSI_W  = 64 - FRAC_BITS;
	localparam int DIF_W  = PSI_W + 1;
	localparam int ERR_W  = PSI_W;
	localparam int THR_W  = 63 - FRAC_BITS;
	localparam int DOM_W  = 62 - FRAC_BITS;
	localparam int KTHR_W = THR_W + 2;
	localparam int LOP_W  = 2 * FRAC_BITS + 1;
	localparam int ONE    = 1 << FRAC_BITS;
	localparam int KOFF_I = (K_OFF < 0) ? 0 : ((K_OFF > ONE) ? ONE : K_OFF);
	localparam logic [FRAC_BITS:0] KOFF_C = (FRAC_BITS + 1)'(KOFF_I);
	localparam logic signed [32:0] OMEGA_S = 33'(OMEGA_AIR_MIN);

	logic signed [63:0]        psi_p_s2;
	logic        [62:0]        thr_p_s2;
	logic        [61:0]        dom_p_s2;
	logic signed [31:0]        yaw_s2;
	logic signed [31:0]        eth_s2;
	logic                      near_s2;

	logic signed [PSI_W-1:0]   psi;
	logic signed [DIF_W-1:0]   ydiff;
	logic        [DIF_W-1:0]   err_abs;
	logic        [THR_W-1:0]   thr_sh;
	logic        [THR_W-1:0]   thr;
	logic        [DOM_W-1:0]   dom_sh;

	logic        [ERR_W-1:0]   err_s3;
	logic        [THR_W-1:0]   thr_s3;
	logic                      cand_pre_s3;
	logic                      near_s3;

	logic        [LOP_W-1:0]   koff_lo;

	logic        [ERR_W-1:0]   err_s4;
	logic        [KTHR_W-1:0]  kthr_s4;
	logic                      dec_s4;
	logic                      cand_pre_s4;
	logic                      near_s4;

	// Stage 2: the three products.
	always_ff @(posedge clk) begin
		psi_p_s2 <= 64'(s1.d_speed) * 64'($signed({1'b0, cfg.yaw_scale}));
		thr_p_s2 <= 63'(cfg.k_rel) * 63'(s1.abs_yaw);
		dom_p_s2 <= 62'(cfg.k_dom) * 62'(s1.oth);
		yaw_s2   <= s1.yaw;
		eth_s2   <= s1.eth;
		near_s2  <= (s1.e <= OMEGA_S) && (s1.e >= -OMEGA_S);
	end

	assign psi     = PSI_W'(psi_p_s2 >>> FRAC_BITS);
	assign ydiff   = DIF_W'(yaw_s2) - DIF_W'(psi);
	assign err_abs = ydiff[DIF_W-1] ? -ydiff : ydiff;
	assign thr_sh  = THR_W'(thr_p_s2 >> FRAC_BITS);
	assign thr     = (THR_W'(cfg.eps_abs) > thr_sh) ? THR_W'(cfg.eps_abs) : thr_sh;
	assign dom_sh  = DOM_W'(dom_p_s2 >> FRAC_BITS);

	// Stage 3: yaw error, threshold and the effort dominance test.
	always_ff @(posedge clk) begin
		err_s3      <= (cfg.yaw_scale != '0) ? ERR_W'(err_abs) : '0;
		thr_s3      <= thr;
		cand_pre_s3 <= (eth_s2 > cfg.eta_on) && !eth_s2[31]
			&& (DOM_W'(eth_s2[30:0]) > dom_sh);
		near_s3     <= near_s2;
	end

	// The fractional part of the threshold is scaled separately so the
	// recontact limit matches the split multiply of the integer part.
	assign koff_lo = LOP_W'(thr_s3[FRAC_BITS-1:0]) * LOP_W'(KOFF_C);

	always_ff @(posedge clk) begin
		err_s4      <= err_s3;
		dec_s4      <= err_s3 > ERR_W'(thr_s3);
		kthr_s4     <= KTHR_W'(thr_s3 >> FRAC_BITS) * KTHR_W'(KOFF_C)
			+ KTHR_W'(koff_lo >> FRAC_BITS);
		cand_pre_s4 <= cand_pre_s3;
		near_s4     <= near_s3;
	end

	always_ff @(posedge clk) begin
		res_s5.yaw_error      <= (|err_s4[ERR_W-1:31]) ? '1 : err_s4[30:0];
		res_s5.decorrelated   <= dec_s4;
		res_s5.slip_candidate <= cfg.enable && dec_s4 && cand_pre_s4;
		res_s5.recontact      <= near_s4 && (KTHR_W'(err_s4) < kthr_s4);
	end

endmodule

[rtl/core/wss_torque_path.sv]
module wss_torque_path #(
	parameter int FRAC_BITS = wss_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  wss_pkg::wss_s1_t           s1,
	input  wss_pkg::wss_cfg_t          cfg,
	output logic signed [64-FRAC_BITS:0] tau_s5
);
	import wss_pkg::*;

	localparam int SH_W  = 64 - FRAC_BITS;
	localparam int TAU_W = SH_W + 1;

	logic signed [63:0]      edot_p_s2;
	logic signed [63:0]      kpe_p_s2;
	logic signed [31:0]      edot_s3;
	logic signed [SH_W-1:0]  kpe_s3;
	logic signed [63:0]      kde_p_s4;
	logic signed [SH_W-1:0]  kpe_s4;

	always_ff @(posedge clk) begin
		edot_p_s2 <= 64'(s1.d_acc) * 64'(INV_TWO_PI_Q32);
		kpe_p_s2  <= 64'(cfg.k_p) * 64'(s1.e);
	end

	always_ff @(posedge clk) begin
		edot_s3 <= 32'(edot_p_s2 >>> 32);
		kpe_s3  <= SH_W'(kpe_p_s2 >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		kde_p_s4 <= 64'(cfg.k_d) * 64'(edot_s3);
		kpe_s4   <= kpe_s3;
	end

	// Both terms are floored on their own before the sum.
	always_ff @(posedge clk) begin
		tau_s5 <= TAU_W'(kpe_s4) + TAU_W'(SH_W'(kde_p_s4 >>> FRAC_BITS));
	end

endmodule

[rtl/core/wheel_slip_sync_detector_top.sv]
// Flow: an item taken with start reaches result, with done high, through a
// six-stage register pipeline.
// Throughput: one item per cycle; busy stays low and results cannot be stalled.
// Reset: arst_n clears all configuration registers to zero and empties the
// pipeline; no result is produced for items in flight at reset.
module wheel_slip_sync_detector_top #(
	parameter int FRAC_BITS     = wss_pkg::FRAC_BITS_DEF,
	parameter int K_OFF         = wss_pkg::K_OFF_DEF,
	parameter int OMEGA_AIR_MIN = wss_pkg::OMEGA_AIR_MIN_DEF,
	parameter int TAU_MAX       = wss_pkg::TAU_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wss_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               start,
	input  wss_pkg::wss_in_t                   sample,
	output logic                               busy,
	output logic                               done,
	output wss_pkg::wss_out_t                  result
);
	import wss_pkg::*;

	localparam int TAU_W   = 65 - FRAC_BITS;
	localparam int ONE     = 1 << FRAC_BITS;
	localparam int LATENCY = 6;
	localparam logic signed [TAU_W-1:0] TAU_HI = TAU_W'(TAU_MAX);
	localparam logic signed [TAU_W-1:0] TAU_LO = -TAU_HI;

	wss_cfg_t                 cfg_q;
	wss_s1_t                  stage_s1;
	wss_s1_t                  stage_d;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                     done_s6;
	wss_out_t                 result_s6;
	wss_yaw_res_t             yaw_s5;
	logic signed [TAU_W-1:0]  tau_s5;
	logic                     accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE:    cfg_q.enable    <= cfg_data[0];
				REG_YAW_SCALE: cfg_q.yaw_scale <= cfg_data[30:0];
				REG_EPS_ABS:   cfg_q.eps_abs   <= cfg_data[30:0];
				REG_K_REL:     cfg_q.k_rel     <= cfg_data[30:0];
				REG_ETA_ON:    cfg_q.eta_on    <= $signed(cfg_data);
				REG_K_DOM:     cfg_q.k_dom     <= cfg_data[30:0];
				REG_K_P:       cfg_q.k_p       <= $signed(cfg_data);
				REG_K_D:       cfg_q.k_d       <= $signed(cfg_data);
			endcase
		end
	end

	always_comb begin
		stage_d.d_speed = 33'(sample.speed_right) - 33'(sample.speed_left);
		stage_d.yaw     = sample.yaw_rate;
		stage_d.abs_yaw = sample.yaw_rate[31] ? 32'(-sample.yaw_rate) : sample.yaw_rate;
		stage_d.eth     = sample.effort_this;
		// The other wheel's effort is floored at 1.0 before the dominance test.
		stage_d.oth     = (sample.effort_other > $signed(32'(ONE)))
			? 31'(sample.effort_other) : 31'(ONE);
		stage_d.e       = 33'(sample.speed_ground) - 33'(sample.speed_air);
		stage_d.d_acc   = 33'(sample.accel_ground) - 33'(sample.accel_air);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			done_s6 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			done_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_d;
		end
	end

	wss_yaw_path #(
		.FRAC_BITS     (FRAC_BITS),
		.K_OFF         (K_OFF),
		.OMEGA_AIR_MIN (OMEGA_AIR_MIN)
	) u_yaw (
		.clk    (clk),
		.s1     (stage_s1),
		.cfg    (cfg_q),
		.res_s5 (yaw_s5)
	);

	wss_torque_path #(
		.FRAC_BITS (FRAC_BITS)
	) u_torque (
		.clk    (clk),
		.s1     (stage_s1),
		.cfg    (cfg_q),
		.tau_s5 (tau_s5)
	);

	always_ff @(posedge clk) begin
		result_s6.yaw_error      <= yaw_s5.yaw_error;
		result_s6.decorrelated   <= yaw_s5.decorrelated;
		result_s6.slip_candidate <= yaw_s5.slip_candidate;
		result_s6.recontact      <= yaw_s5.recontact;
		if (tau_s5 > TAU_HI) begin
			result_s6.sync_torque    <= 32'(TAU_HI);
			result_s6.torque_clamped <= 1'b1;
		end else if (tau_s5 < TAU_LO) begin
			result_s6.sync_torque    <= 32'(TAU_LO);
			result_s6.torque_clamped <= 1'b1;
		end else begin
			result_s6.sync_torque    <= tau_s5[31:0];
			result_s6.torque_clamped <= 1'b0;
		end
	end

	assign done   = done_s6;
	assign result = result_s6;

`ifndef SYNTHESIS
	a_item_completes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted item did not produce a result on time");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without a matching accepted item");

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.torque_clamped |->
			(result.sync_torque == 32'(TAU_HI)) || (result.sync_torque == 32'(TAU_LO)))
		else $error("clamped torque is not at the clamp limit");

	a_candidate_gated: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.slip_candidate |-> result.decorrelated && cfg_q.enable)
		else $error("slip candidate raised without decorrelation or enable");
`endif

endmodule

[tb/wss_result_checker.sv]
`timescale 1ns / 1ps

module wss_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wss_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           start,
	input  logic                           busy,
	input  wss_pkg::wss_in_t               sample,
	input  logic                           done,
	input  wss_pkg::wss_out_t              result,
	output int                             n_results,
	output int                             n_fail,
	output int                             n_dec,
	output int                             n_slip,
	output int                             n_rec,
	output int                             n_clamp
);

	import wss_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;

	wss_cfg_t regs;
	wss_out_t pending_results[$];
	int       n_mismatch;
	int       got_cnt;
	int       dec_cnt;
	int       slip_cnt;
	int       rec_cnt;
	int       clamp_cnt;

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic wss_out_t predict_slip_sync(wss_in_t s, wss_cfg_t c);
		longint   one;
		longint   sl, sr, yaw, eth, eot, sg, sa, ag, aa;
		longint   thr, err, psi, oth, dom, koff, kthr, e, edot, tau;
		logic     dec, cand, rec, clamped;
		wss_out_t r;
		one = longint'(1) <<< FRAC;
		sl  = longint'($signed(s.speed_left));
		sr  = longint'($signed(s.speed_right));
		yaw = longint'($signed(s.yaw_rate));
		eth = longint'($signed(s.effort_this));
		eot = longint'($signed(s.effort_other));
		sg  = longint'($signed(s.speed_ground));
		sa  = longint'($signed(s.speed_air));
		ag  = longint'($signed(s.accel_ground));
		aa  = longint'($signed(s.accel_air));

		thr = (longint'(c.k_rel) * mag(yaw)) >>> FRAC;
		if (longint'(c.eps_abs) > thr)
			thr = longint'(c.eps_abs);

		// A zero scale means the track is too small to trust, so no yaw check.
		err = 0;
		dec = 1'b0;
		if (c.yaw_scale != 0) begin
			psi = ((sr - sl) * longint'(c.yaw_scale)) >>> FRAC;
			err = mag(yaw - psi);
			dec = err > thr;
		end

		oth  = (eot > one) ? eot : one;
		dom  = (longint'(c.k_dom) * oth) >>> FRAC;
		cand = c.enable && dec && (eth > longint'($signed(c.eta_on))) && (eth > dom);

		koff = K_OFF_DEF;
		if (koff < 0)
			koff = 0;
		if (koff > one)
			koff = one;
		kthr = (thr >>> FRAC) * koff + (((thr & (one - 1)) * koff) >>> FRAC);
		rec  = (mag(sa - sg) <= longint'(OMEGA_AIR_MIN_DEF)) && (err < kthr);

		e    = sg - sa;
		edot = ((ag - aa) * longint'(INV_TWO_PI_Q32)) >>> 32;
		tau  = ((longint'($signed(c.k_p)) * e) >>> FRAC)
			+ ((longint'($signed(c.k_d)) * edot) >>> FRAC);
		clamped = 1'b0;
		if (tau > longint'(TAU_MAX_DEF)) begin
			tau     = TAU_MAX_DEF;
			clamped = 1'b1;
		end else if (tau < -longint'(TAU_MAX_DEF)) begin
			tau     = -longint'(TAU_MAX_DEF);
			clamped = 1'b1;
		end

		r.yaw_error      = (err > 64'sd2147483647) ? 31'h7FFF_FFFF : err[30:0];
		r.decorrelated   = dec;
		r.slip_candidate = cand;
		r.recontact      = rec;
		r.sync_torque    = tau[31:0];
		r.torque_clamped = clamped;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_mismatch++;
	endtask

	task automatic check_field(string name, longint got, longint want_v);
		if (got != want_v)
			report_mismatch($sformatf("%s got %0d, predicted %0d", name, got, want_v));
	endtask

	task automatic compare_result(wss_out_t got, wss_out_t want_r);
		check_field("yaw_error", got.yaw_error, want_r.yaw_error);
		check_field("decorrelated", got.decorrelated, want_r.decorrelated);
		check_field("slip_candidate", got.slip_candidate, want_r.slip_candidate);
		check_field("recontact", got.recontact, want_r.recontact);
		check_field("sync_torque", longint'($signed(got.sync_torque)),
			longint'($signed(want_r.sync_torque)));
		check_field("torque_clamped", got.torque_clamped, want_r.torque_clamped);
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE:    regs.enable    <= cfg_data[0];
				REG_YAW_SCALE: regs.yaw_scale <= cfg_data[30:0];
				REG_EPS_ABS:   regs.eps_abs   <= cfg_data[30:0];
				REG_K_REL:     regs.k_rel     <= cfg_data[30:0];
				REG_ETA_ON:    regs.eta_on    <= cfg_data;
				REG_K_DOM:     regs.k_dom     <= cfg_data[30:0];
				REG_K_P:       regs.k_p       <= cfg_data;
				REG_K_D:       regs.k_d       <= cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		wss_out_t want_r;
		if (!arst_n) begin
			pending_results.delete();
			n_mismatch = 0;
			got_cnt    = 0;
			dec_cnt    = 0;
			slip_cnt   = 0;
			rec_cnt    = 0;
			clamp_cnt  = 0;
			n_results <= 0;
			n_fail    <= 0;
			n_dec     <= 0;
			n_slip    <= 0;
			n_rec     <= 0;
			n_clamp   <= 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no sample waiting");
				end else begin
					want_r = pending_results.pop_front();
					compare_result(result, want_r);
				end
				got_cnt++;
			end
			if (start && !busy) begin
				want_r = predict_slip_sync(sample, regs);
				pending_results.push_back(want_r);
				dec_cnt   += want_r.decorrelated;
				slip_cnt  += want_r.slip_candidate;
				rec_cnt   += want_r.recontact;
				clamp_cnt += want_r.torque_clamped;
			end
			n_results <= got_cnt;
			n_fail    <= n_mismatch + pending_results.size();
			n_dec     <= dec_cnt;
			n_slip    <= slip_cnt;
			n_rec     <= rec_cnt;
			n_clamp   <= clamp_cnt;
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	import wss_pkg::*;

	localparam int ONE       = 65536;
	localparam int DRAIN_LAT = 8;
	localparam int PHASES    = 8;
	localparam int PER_PHASE = 107;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	wss_in_t               smp;
	logic                  busy;
	logic                  done;
	wss_out_t              res;

	int n_results, n_fail, n_dec, n_slip, n_rec, n_clamp;
	int n_sent;
	int n_settings;
	int idle_pct;
	logic [31:0] cur_scale;

	wheel_slip_sync_detector_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.sample    (smp),
		.busy      (busy),
		.done      (done),
		.result    (res)
	);

	wss_result_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.sample    (smp),
		.done      (done),
		.result    (res),
		.n_results (n_results),
		.n_fail    (n_fail),
		.n_dec     (n_dec),
		.n_slip    (n_slip),
		.n_rec     (n_rec),
		.n_clamp   (n_clamp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic wss_in_t mk(
		logic signed [31:0] sl, logic signed [31:0] sr, logic signed [31:0] yaw,
		logic signed [31:0] eth, logic signed [31:0] eot, logic signed [31:0] sg,
		logic signed [31:0] sa, logic signed [31:0] ag, logic signed [31:0] aa);
		wss_in_t s;
		s.speed_left   = sl;
		s.speed_right  = sr;
		s.yaw_rate     = yaw;
		s.effort_this  = eth;
		s.effort_other = eot;
		s.speed_ground = sg;
		s.speed_air    = sa;
		s.accel_ground = ag;
		s.accel_air    = aa;
		return s;
	endfunction

	// Mixes full-range words with small and extreme ones so that the
	// thresholds and the torque clamp are hit from both sides.
	function automatic logic [31:0] rand_q();
		int sh;
		sh = $urandom_range(5);
		case (sh)
			0: return $urandom;
			1: return $urandom_range(0, 1 << 19) - (1 << 18);
			2: return $urandom_range(0, 1 << 13) - (1 << 12);
			3: begin
				case ($urandom_range(4))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
			default: return $urandom_range(0, 1 << 25) - (1 << 24);
		endcase
	endfunction

	function automatic logic [31:0] rand_reg();
		case ($urandom_range(6))
			0: return $urandom;
			1: return 32'h0000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return $urandom_range(0, 4 * ONE) | ($urandom & 32'h8000_0000);
			default: return $urandom_range(0, 2 * ONE);
		endcase
	endfunction

	function automatic wss_in_t rand_sample(logic [31:0] scale);
		wss_in_t s;
		longint  psi;
		s.speed_left  = rand_q();
		s.speed_right = ($urandom_range(1)) ? rand_q() : s.speed_left + rand_q();
		// Half the time the gyro agrees with the wheels up to a little noise.
		if ($urandom_range(1)) begin
			psi = ((longint'($signed(s.speed_right)) - longint'($signed(s.speed_left)))
				* longint'(scale[30:0])) >>> FRAC_BITS_DEF;
			s.yaw_rate = psi[31:0] + ($urandom_range(0, 1 << 15) - (1 << 14));
		end else begin
			s.yaw_rate = rand_q();
		end
		s.effort_this  = rand_q();
		s.effort_other = rand_q();
		s.speed_ground = rand_q();
		s.speed_air    = ($urandom_range(1)) ? rand_q()
			: s.speed_ground + ($urandom_range(0, 140000) - 70000);
		s.accel_ground = rand_q();
		s.accel_air    = ($urandom_range(2) == 0)
			? s.accel_ground + ($urandom_range(0, 1 << 18) - (1 << 17)) : rand_q();
		return s;
	endfunction

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (n_results < n_sent)
			@(posedge clk);
		repeat (DRAIN_LAT) @(posedge clk);
	endtask

	task automatic apply_setting(logic [31:0] vals [8]);
		drain();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		cur_scale = vals[REG_YAW_SCALE];
		n_settings++;
		@(posedge clk);
	endtask

	task automatic send_sample(wss_in_t s);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		smp   <= s;
		do
			@(posedge clk);
		while (busy);
		n_sent++;
	endtask

	initial begin : stimulus
		logic [31:0] setting [8];
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		start      = 1'b0;
		smp        = '0;
		n_sent     = 0;
		n_settings = 0;
		idle_pct   = 0;
		cur_scale  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Registers still at reset: zero scale and enable clear.
		send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_sample(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_sample(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));

		// Plausible robot tuning.
		setting = '{32'd1, ONE, 32'd6554, 32'd13107, ONE / 2, 32'd98304, ONE, ONE / 2};
		apply_setting(setting);
		send_sample(mk(0, ONE, ONE, 0, 0, ONE, ONE, 0, 0));
		send_sample(mk(0, 2 * ONE, 0, 3 * ONE, ONE, 0, 0, 0, 0));
		send_sample(mk(0, 2 * ONE, 0, 2 * ONE, -5 * ONE, 0, 0, 0, 0));
		send_sample(mk(0, 2 * ONE, 0, ONE, 0, 0, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, 10 * ONE, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, -10 * ONE, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, ONE, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, ONE / 2, ONE / 4, 3 * ONE, ONE));
		send_sample(mk(0, 0, 0, 0, 0, ONE, 2 * ONE, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, ONE, 2 * ONE + 1, 0, 0));
		send_sample(mk(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0));
		send_sample(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
		send_sample(mk(0, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));

		// Every register at its extreme.
		idle_pct = 60;
		setting = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
		apply_setting(setting);
		send_sample(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_sample(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
		send_sample(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));

		// A high effort floor that blocks a wheel which already dominates.
		setting = '{32'd1, ONE, 0, 0, 4 * ONE, ONE / 2, ONE, 0};
		apply_setting(setting);
		send_sample(mk(0, 2 * ONE, 0, 3 * ONE, ONE, 0, 0, 0, 0));
		send_sample(mk(0, 2 * ONE, 0, 5 * ONE, ONE, 0, 0, 0, 0));

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 60;
				2: idle_pct = 0;
				default: idle_pct = 22;
			endcase
			for (int i = 0; i < 8; i++)
				setting[i] = rand_reg();
			// Keep slip detection mostly enabled; bit 0 alone matters.
			setting[REG_ENABLE] = ($urandom & 32'hFFFF_FFFE) | ($urandom_range(3) != 0);
			if (ph == 0)
				setting[REG_YAW_SCALE] = 0;
			apply_setting(setting);
			for (int n = 0; n < PER_PHASE; n++)
				send_sample(rand_sample(cur_scale));
		end

		drain();
		$display("Checked %0d samples over %0d register settings.", n_sent, n_settings);
		$display("Predicted %0d decorrelated, %0d slip, %0d recontact, %0d clamped.",
			n_dec, n_slip, n_rec, n_clamp);
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
rtl/core/wss_pkg.sv
rtl/core/wss_yaw_path.sv
rtl/core/wss_torque_path.sv
rtl/core/wheel_slip_sync_detector_top.sv
tb/wss_result_checker.sv
tb/testbench.sv
